// ----- hdl/imupcf_pkg.sv -----
package imupcf_pkg;

	// APB address width: five registers on 32-bit words
	localparam int APB_AW = 5;

	// register map (word index)
	localparam logic [2:0] REG_BLEND_WEIGHT  = 3'd0;
	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd1;
	localparam logic [2:0] REG_GYRO_SCALE    = 3'd2;
	localparam logic [2:0] REG_ZERO_OFFSET   = 3'd3;
	localparam logic [2:0] REG_ACCEL_ONLY    = 3'd4;

	// fault codes
	typedef logic [1:0] fault_t;
	localparam fault_t FAULT_OK    = 2'd0;
	localparam fault_t FAULT_STUCK = 2'd1;
	localparam fault_t FAULT_RAIL  = 2'd2;

	// sensor offsets and rail values
	localparam logic signed [16:0] OFS_AX  = 17'sd15;
	localparam logic signed [16:0] OFS_AZ  = 17'sd20;
	localparam logic signed [16:0] OFS_GY  = 17'sd6;
	localparam logic signed [15:0] RAIL_HI = 16'sh7FFF;
	localparam logic signed [15:0] RAIL_LO = 16'sh8000;

	// datapath widths
	localparam int MA_W   = 40;            // multiplier operand A
	localparam int MB_W   = 21;            // multiplier operand B
	localparam int PR_W   = MA_W + MB_W;   // product
	localparam int FILT_W = 32;
	localparam int RATE_W = 37;
	localparam int GANG_W = 39;
	localparam int CW     = 34;            // CORDIC x/y
	localparam int ZW     = 26;            // CORDIC angle
	localparam int TAB_W  = 23;
	localparam int TAB_IX = 5;

	// low-pass coefficients, Q0.16
	localparam logic signed [MB_W-1:0] CF_ACC     = 21'sd58982;
	localparam logic signed [MB_W-1:0] CF_ACC_INV = 21'sd6554;
	localparam logic signed [MB_W-1:0] CF_GYR     = 21'sd54395;
	localparam logic signed [MB_W-1:0] CF_GYR_INV = 21'sd11141;

	localparam logic signed [ZW-1:0] Z_180 = 26'sd11796480;

	localparam logic signed [PR_W:0]   RND16_W = 62'sd32768;
	localparam logic signed [PR_W-1:0] RND16   = 61'sd32768;
	localparam logic signed [PR_W-1:0] RND14   = 61'sd8192;

	// arctan(2^-i) in Q16.16 degrees
	function automatic logic [TAB_W-1:0] atan_deg(input logic [TAB_IX-1:0] i);
		logic [TAB_W-1:0] r;
		unique case (i)
			5'd0:    r = 23'd2949120;
			5'd1:    r = 23'd1740967;
			5'd2:    r = 23'd919879;
			5'd3:    r = 23'd466945;
			5'd4:    r = 23'd234379;
			5'd5:    r = 23'd117304;
			5'd6:    r = 23'd58666;
			5'd7:    r = 23'd29335;
			5'd8:    r = 23'd14668;
			5'd9:    r = 23'd7334;
			5'd10:   r = 23'd3667;
			5'd11:   r = 23'd1833;
			5'd12:   r = 23'd917;
			5'd13:   r = 23'd458;
			5'd14:   r = 23'd229;
			5'd15:   r = 23'd115;
			5'd16:   r = 23'd57;
			5'd17:   r = 23'd29;
			5'd18:   r = 23'd14;
			5'd19:   r = 23'd7;
			5'd20:   r = 23'd4;
			5'd21:   r = 23'd2;
			5'd22:   r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PR_W:0] v);
		logic signed [31:0] r;
		if (&v[PR_W:31] || ~|v[PR_W:31]) begin
			r = v[31:0];
		end else if (v[PR_W]) begin
			r = 32'sh80000000;
		end else begin
			r = 32'sh7FFFFFFF;
		end
		return r;
	endfunction

endpackage

// ----- hdl/imupcf_if.sv -----
interface imupcf_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_y;

	modport source(output valid, output accel_x, output accel_z, output gyro_y, input ready);
	modport sink(input valid, input accel_x, input accel_z, input gyro_y, output ready);
endinterface

interface imupcf_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pitch;
	logic [1:0]         fault;

	modport source(output valid, output pitch, output fault, input ready);
	modport sink(input valid, input pitch, input fault, output ready);
endinterface

// ----- hdl/imu_pitch_complementary_filter.sv -----
// Pitch estimator for one accelerometer/gyro sample per transaction. Each sample
// (accel X, accel Z, gyro Y) is checked for stuck data (three unchanged samples in a
// row, fault 1) and rail values (+32767/-32768, fault 2, wins over stuck); a faulty
// sample is still processed. Offsets are removed and each axis goes through a
// first-order low-pass from a zero start. Accel pitch is -atan2(ax, az) from an
// iterative CORDIC of CORDIC_STEPS steps; it is blended with the integrated gyro
// angle using blend_weight, or used alone when accel_only is set. Output pitch is
// zero_offset minus the angle, Q16.16 degrees, saturated to 32 bits. All products
// go through a single 40x21 multiplier with a registered product and an
// accumulator, stepped by a small sequencer; the CORDIC shift-add unit runs
// alongside the gyro products. Ready is low from the acceptance of a sample until
// its result is loaded, a time set by the CORDIC iteration count plus the serial
// filter and blend products. The result sits in an output register, so the next
// sample is taken while a finished result waits. Config registers (APB, word
// aligned): 0x00 blend_weight, 0x04 sample_period, 0x08 gyro_scale, 0x0C
// zero_offset, 0x10 accel_only; write only while idle.
module imu_pitch_complementary_filter #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [imupcf_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	imupcf_in_if.sink                     sample,
	imupcf_out_if.source                  result
);
	import imupcf_pkg::*;

	localparam int ITW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [ITW-1:0] IT_LAST = ITW'(CORDIC_STEPS - 1);

	// sequencer states
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_F0   = 4'd1;   // ax new term
	localparam logic [3:0] S_F1   = 4'd2;   // ax old term
	localparam logic [3:0] S_F2   = 4'd3;   // az new term, ax done
	localparam logic [3:0] S_F3   = 4'd4;   // az old term
	localparam logic [3:0] S_F4   = 4'd5;   // gy new term, az done
	localparam logic [3:0] S_F5   = 4'd6;   // gy old term
	localparam logic [3:0] S_F6   = 4'd7;   // gy done, CORDIC load
	localparam logic [3:0] S_G0   = 4'd8;   // filt_gy * gyro_scale
	localparam logic [3:0] S_G1   = 4'd9;   // rate
	localparam logic [3:0] S_G2   = 4'd10;  // rate * sample_period
	localparam logic [3:0] S_G3   = 4'd11;  // gyro angle
	localparam logic [3:0] S_B0   = 4'd12;  // wait CORDIC, ay * w
	localparam logic [3:0] S_B1   = 4'd13;  // gyro angle * (1 - w)
	localparam logic [3:0] S_B2   = 4'd14;  // new angle
	localparam logic [3:0] S_OUT  = 4'd15;  // load output register

	logic [3:0] state_q;

	// config registers
	logic [15:0]        w_q;
	logic [15:0]        sp_q;
	logic [19:0]        gs_q;
	logic signed [24:0] zofs_q;
	logic               aonly_q;

	// model state
	logic signed [15:0]       prev_ax_q, prev_az_q, prev_gy_q;
	logic [1:0]               stuck_q;
	logic signed [FILT_W-1:0] filt_ax_q, filt_az_q, filt_gy_q;
	logic signed [31:0]       angle_q;

	// datapath
	logic signed [PR_W-1:0]   prod_q, acc_q;
	logic signed [RATE_W-1:0] rate_q;
	logic signed [GANG_W-1:0] gang_q;
	fault_t                   fault_q, fault_out_q;
	logic signed [31:0]       pitch_q;
	logic                     out_valid_q;

	// CORDIC
	logic signed [CW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [ITW-1:0]       it_q;
	logic                 cbusy_q;
	logic                 czero_q;

	// ---------------- APB ----------------
	logic       cfg_wr;
	logic [2:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = paddr[APB_AW-1:2];

	always_comb begin
		unique case (cfg_idx)
			REG_BLEND_WEIGHT:  prdata = {16'd0, w_q};
			REG_SAMPLE_PERIOD: prdata = {16'd0, sp_q};
			REG_GYRO_SCALE:    prdata = {12'd0, gs_q};
			REG_ZERO_OFFSET:   prdata = {{7{zofs_q[24]}}, zofs_q};
			REG_ACCEL_ONLY:    prdata = {31'd0, aonly_q};
			default:           prdata = 32'd0;
		endcase
	end

	// ---------------- input checks ----------------
	logic   in_acc;
	logic   same_smp;
	logic   rail;
	logic [1:0] stuck_inc;

	assign sample.ready = (state_q == S_IDLE);
	assign in_acc       = sample.valid & sample.ready;
	assign same_smp     = (sample.accel_x == prev_ax_q) && (sample.accel_z == prev_az_q) &&
		(sample.gyro_y == prev_gy_q);
	assign rail = (sample.accel_x == RAIL_HI) || (sample.accel_x == RAIL_LO) ||
		(sample.accel_z == RAIL_HI) || (sample.accel_z == RAIL_LO) ||
		(sample.gyro_y == RAIL_HI) || (sample.gyro_y == RAIL_LO);
	assign stuck_inc = stuck_q + 2'd1;

	// ---------------- shared multiplier operands ----------------
	logic signed [16:0] ofs_ax, ofs_az, ofs_gy;
	logic [16:0]        inv_w;
	logic signed [ZW-1:0] ay;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;

	// prev_*_q hold the sample in flight once it is accepted
	assign ofs_ax = {prev_ax_q[15], prev_ax_q} - OFS_AX;
	assign ofs_az = {prev_az_q[15], prev_az_q} - OFS_AZ;
	assign ofs_gy = {prev_gy_q[15], prev_gy_q} + OFS_GY;
	assign inv_w  = 17'h10000 - {1'b0, w_q};
	assign ay     = czero_q ? '0 : -cz_q;

	always_comb begin
		unique case (state_q)
			S_F0: begin
				mul_a = {{(MA_W-31){ofs_ax[16]}}, ofs_ax, 14'd0};
				mul_b = CF_ACC;
			end
			S_F1: begin
				mul_a = {{(MA_W-FILT_W){filt_ax_q[FILT_W-1]}}, filt_ax_q};
				mul_b = CF_ACC_INV;
			end
			S_F2: begin
				mul_a = {{(MA_W-31){ofs_az[16]}}, ofs_az, 14'd0};
				mul_b = CF_ACC;
			end
			S_F3: begin
				mul_a = {{(MA_W-FILT_W){filt_az_q[FILT_W-1]}}, filt_az_q};
				mul_b = CF_ACC_INV;
			end
			S_F4: begin
				mul_a = {{(MA_W-31){ofs_gy[16]}}, ofs_gy, 14'd0};
				mul_b = CF_GYR;
			end
			S_F5: begin
				mul_a = {{(MA_W-FILT_W){filt_gy_q[FILT_W-1]}}, filt_gy_q};
				mul_b = CF_GYR_INV;
			end
			S_G0: begin
				mul_a = {{(MA_W-FILT_W){filt_gy_q[FILT_W-1]}}, filt_gy_q};
				mul_b = {1'b0, gs_q};
			end
			S_G2: begin
				mul_a = {{(MA_W-RATE_W){rate_q[RATE_W-1]}}, rate_q};
				mul_b = {5'd0, sp_q};
			end
			S_B0: begin
				mul_a = {{(MA_W-ZW){ay[ZW-1]}}, ay};
				mul_b = {5'd0, w_q};
			end
			S_B1: begin
				mul_a = {{(MA_W-GANG_W){gang_q[GANG_W-1]}}, gang_q};
				mul_b = {4'd0, inv_w};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// ---------------- rounding ----------------
	logic signed [PR_W:0]   acc_sum, acc_rnd;
	logic signed [PR_W-1:0] prod_r14, prod_r16;
	logic signed [32:0]     out_diff;

	assign acc_sum  = {acc_q[PR_W-1], acc_q} + {prod_q[PR_W-1], prod_q} + RND16_W;
	assign acc_rnd  = acc_sum >>> 16;
	assign prod_r14 = (prod_q + RND14) >>> 14;
	assign prod_r16 = (prod_q + RND16) >>> 16;
	assign out_diff = {{8{zofs_q[24]}}, zofs_q} - {angle_q[31], angle_q};

	// ---------------- CORDIC step ----------------
	logic signed [CW-1:0] cdx, cdy, ld_x, ld_y;
	logic signed [ZW-1:0] ctab;

	assign cdx  = cy_q >>> it_q;
	assign cdy  = cx_q >>> it_q;
	assign ctab = {{(ZW-TAB_W){1'b0}}, atan_deg(TAB_IX'(it_q))};
	assign ld_y = {{(CW-FILT_W){filt_ax_q[FILT_W-1]}}, filt_ax_q};
	assign ld_x = {{(CW-FILT_W){filt_az_q[FILT_W-1]}}, filt_az_q};

	// ---------------- control and state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			w_q         <= 16'd1638;
			sp_q        <= 16'd655;
			gs_q        <= 20'd3996;
			zofs_q      <= 25'sd458752;
			aonly_q     <= 1'b0;
			prev_ax_q   <= '0;
			prev_az_q   <= '0;
			prev_gy_q   <= '0;
			stuck_q     <= '0;
			filt_ax_q   <= '0;
			filt_az_q   <= '0;
			filt_gy_q   <= '0;
			angle_q     <= '0;
			out_valid_q <= 1'b0;
			cbusy_q     <= 1'b0;
			it_q        <= '0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_BLEND_WEIGHT:  w_q     <= pwdata[15:0];
					REG_SAMPLE_PERIOD: sp_q    <= pwdata[15:0];
					REG_GYRO_SCALE:    gs_q    <= pwdata[19:0];
					REG_ZERO_OFFSET:   zofs_q  <= pwdata[24:0];
					REG_ACCEL_ONLY:    aonly_q <= pwdata[0];
					default: ;
				endcase
			end

			// in S_OUT a taken transaction is refilled below
			if (result.valid && result.ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end

			if (cbusy_q) begin
				it_q <= it_q + 1'b1;
				if (it_q == IT_LAST) begin
					cbusy_q <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						prev_ax_q <= sample.accel_x;
						prev_az_q <= sample.accel_z;
						prev_gy_q <= sample.gyro_y;
						if (!same_smp || stuck_inc == 2'd3) begin
							stuck_q <= '0;
						end else begin
							stuck_q <= stuck_inc;
						end
						state_q <= S_F0;
					end
				end
				S_F2: begin
					filt_ax_q <= acc_rnd[FILT_W-1:0];
					state_q   <= S_F3;
				end
				S_F4: begin
					filt_az_q <= acc_rnd[FILT_W-1:0];
					state_q   <= S_F5;
				end
				S_F6: begin
					filt_gy_q <= acc_rnd[FILT_W-1:0];
					cbusy_q   <= 1'b1;
					it_q      <= '0;
					state_q   <= S_G0;
				end
				S_B0: begin
					if (!cbusy_q) begin
						state_q <= S_B1;
					end
				end
				S_B2: begin
					if (aonly_q) begin
						angle_q <= {{(32-ZW){ay[ZW-1]}}, ay};
					end else begin
						angle_q <= sat32(acc_rnd);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= state_q + 4'd1;
			endcase
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;

		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (rail) begin
						fault_q <= FAULT_RAIL;
					end else if (same_smp && stuck_inc == 2'd3) begin
						fault_q <= FAULT_STUCK;
					end else begin
						fault_q <= FAULT_OK;
					end
				end
			end
			S_F1, S_F3, S_F5, S_B1: acc_q <= prod_q;
			S_F6: begin
				// atan2(y = ax, x = az); negative x folds through +-180 degrees
				czero_q <= (ld_x == '0) && (ld_y == '0);
				if (ld_x[CW-1]) begin
					cx_q <= -ld_x;
					cy_q <= -ld_y;
					cz_q <= ld_y[CW-1] ? -Z_180 : Z_180;
				end else begin
					cx_q <= ld_x;
					cy_q <= ld_y;
					cz_q <= '0;
				end
			end
			S_G1: rate_q <= prod_r14[RATE_W-1:0];
			S_G3: gang_q <= {{(GANG_W-32){angle_q[31]}}, angle_q} + prod_r16[GANG_W-1:0];
			S_OUT: begin
				if (!out_valid_q || result.ready) begin
					pitch_q     <= sat32({{(PR_W-32){out_diff[32]}}, out_diff});
					fault_out_q <= fault_q;
				end
			end
			default: ;
		endcase

		if (cbusy_q) begin
			if (!cy_q[CW-1]) begin
				cx_q <= cx_q + cdx;
				cy_q <= cy_q - cdy;
				cz_q <= cz_q + ctab;
			end else begin
				cx_q <= cx_q - cdx;
				cy_q <= cy_q + cdy;
				cz_q <= cz_q - ctab;
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.pitch = pitch_q;
	assign result.fault = fault_out_q;

endmodule
